>>> src/srarq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the selective-repeat ARQ sender core.
// No dependencies; imported by the top-level sender core.
package srarq_pkg;

    // window size default
    localparam int WINDOW_DEPTH_DEF = 8;

    // field widths fixed by the frame format
    localparam int TYPE_W    = 8;
    localparam int ADDR_W    = 8;
    localparam int SEQ_W     = 6;
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 2;
    localparam int EVENT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_SUBMIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RX     = 2'd2;

    // result events
    localparam logic [EVENT_W-1:0] EV_TX     = 2'd0;
    localparam logic [EVENT_W-1:0] EV_DONE   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_REJECT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TYPE      = 2'd1;

    // register reset values
    localparam logic [CFG_W-1:0] TIMEOUT_LIMIT_RST = 8'd8;
    localparam logic [CFG_W-1:0] ACK_TYPE_RST      = 8'd2;

    // frame type used for padding the window
    localparam logic [TYPE_W-1:0] PAD_TYPE = 8'h01;

    // one window slot as held in the frame store
    typedef struct packed {
        logic [TYPE_W-1:0] ftype;
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] src;
        logic [DATA_W-1:0] data;
    } frame_entry_t;

    localparam int ENTRY_W = $bits(frame_entry_t);

endpackage

>>> src/srarq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srarq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/selective_repeat_arq_sender_core.sv
`timescale 1ns / 1ps
// Top level of the selective-repeat ARQ sender: sequencer, ack tracking, output register.
// Depends on srarq_pkg and srarq_ram.
//
// Requests are taken one at a time; in_stall stays high while a window is padded, sent or
// resent, or while a single event result waits to be loaded. A submitted frame that does not
// fill the window, or a reception that causes no result, leaves in_stall low. Sending a
// window walks the frame store through its single read port: on end of data the pad slots
// are written first, then each frame sent is read and then loaded into the one-entry output
// register, which out_stall can hold; on a resend acknowledged slots are passed over. Frame
// store contents need no clearing: every slot is written before it is sent.
module selective_repeat_arq_sender_core
    import srarq_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [TYPE_W-1:0]    frame_type,
    input  logic [SEQ_W-1:0]     seq_number,
    input  logic [ADDR_W-1:0]    dest_addr,
    input  logic [ADDR_W-1:0]    src_addr,
    input  logic [DATA_W-1:0]    payload,
    input  logic                 crc_good,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EVENT_W-1:0]   event_res,
    output logic [TYPE_W-1:0]    out_type,
    output logic [SEQ_W-1:0]     out_seq,
    output logic [ADDR_W-1:0]    out_dest,
    output logic [ADDR_W-1:0]    out_src,
    output logic [DATA_W-1:0]    out_payload,
    output logic                 last,
    // configuration channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);
    localparam logic [SEQ_W:0]   SEQ_LIMIT = (SEQ_W + 1)'(WINDOW_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_SINGLE = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        fill_reg, fill_next;
    logic                    awaiting_reg, awaiting_next;
    logic [WINDOW_DEPTH-1:0] bitmap_reg, bitmap_next;
    logic [CNT_W-1:0]        ack_count_reg, ack_count_next;
    logic [CFG_W-1:0]        timeout_reg, timeout_next;
    logic                    unacked_only_reg, unacked_only_next;
    logic [EVENT_W-1:0]      single_ev_reg, single_ev_next;
    logic [ADDR_W-1:0]       pad_dest_reg, pad_dest_next;
    logic [ADDR_W-1:0]       pad_src_reg, pad_src_next;
    logic [CFG_W-1:0]        timeout_limit_reg;
    logic [CFG_W-1:0]        ack_type_reg;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [EVENT_W-1:0]      out_event_reg, out_event_next;
    frame_entry_t            out_frame_reg, out_frame_next;
    logic [SEQ_W-1:0]        out_seq_reg, out_seq_next;
    logic                    out_last_reg, out_last_next;

    // frame store ports
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    frame_entry_t            ram_wentry;
    logic [ENTRY_W-1:0]      ram_rdata;
    frame_entry_t            ram_rentry;

    logic                    in_accept;
    logic                    out_free;
    logic [WINDOW_DEPTH-1:0] seq_onehot;
    logic                    ack_is_new;
    logic [CNT_W-1:0]        ack_count_step;
    logic [CFG_W-1:0]        timeout_step;
    logic [WINDOW_DEPTH-1:0] send_mask;
    logic [WINDOW_DEPTH:0]   send_tail;
    logic                    more_to_send;
    logic                    slot_skip;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cfg_ready  = 1'b1;
    assign ram_rentry = frame_entry_t'(ram_rdata);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
            ack_type_reg      <= ACK_TYPE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_TIMEOUT_LIMIT)
            begin
                timeout_limit_reg <= cfg_data;
            end
            else if (cfg_index == CFG_ACK_TYPE)
            begin
                ack_type_reg <= cfg_data;
            end
        end
    end

    // frame store
    srarq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wentry),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    // ack decode and timeout step
    assign seq_onehot     = WINDOW_DEPTH'(1) << seq_number;
    assign ack_is_new     = !(|(bitmap_reg & seq_onehot));
    assign ack_count_step = ack_count_reg + CNT_W'(ack_is_new);
    assign timeout_step   = timeout_reg + CFG_W'(1);

    // which slots are still to go out after the current one
    assign send_mask    = unacked_only_reg ? ~bitmap_reg : {WINDOW_DEPTH{1'b1}};
    assign send_tail    = {1'b0, send_mask} >> idx_reg;
    assign more_to_send = |(send_tail >> 1);
    assign slot_skip    = unacked_only_reg && bitmap_reg[idx_reg];

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        fill_next         = fill_reg;
        awaiting_next     = awaiting_reg;
        bitmap_next       = bitmap_reg;
        ack_count_next    = ack_count_reg;
        timeout_next      = timeout_reg;
        unacked_only_next = unacked_only_reg;
        single_ev_next    = single_ev_reg;
        pad_dest_next     = pad_dest_reg;
        pad_src_next      = pad_src_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_event_next    = out_event_reg;
        out_frame_next    = out_frame_reg;
        out_seq_next      = out_seq_reg;
        out_last_next     = out_last_reg;
        ram_we            = 1'b0;
        ram_waddr         = fill_reg;
        ram_wentry        = '{ftype: frame_type, dest: dest_addr, src: src_addr, data: payload};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!awaiting_reg)
                    begin
                        if (kind == KIND_SUBMIT)
                        begin
                            ram_we        = 1'b1;
                            pad_dest_next = dest_addr;
                            pad_src_next  = src_addr;
                            if (fill_reg == IDX_LAST)
                            begin
                                // window full: start sending it
                                fill_next         = '0;
                                awaiting_next     = 1'b1;
                                bitmap_next       = '0;
                                ack_count_next    = '0;
                                timeout_next      = '0;
                                unacked_only_next = 1'b0;
                                idx_next          = '0;
                                state_next        = ST_SCAN;
                            end
                            else
                            begin
                                fill_next = fill_reg + IDX_W'(1);
                            end
                        end
                        else if (kind == KIND_EOD && fill_reg != '0)
                        begin
                            idx_next   = fill_reg;
                            fill_next  = '0;
                            state_next = ST_PAD;
                        end
                        else
                        begin
                            single_ev_next = EV_REJECT;
                            state_next     = ST_SINGLE;
                        end
                    end
                    else if (kind != KIND_RX)
                    begin
                        single_ev_next = EV_REJECT;
                        state_next     = ST_SINGLE;
                    end
                    else if (crc_good && (frame_type != ack_type_reg
                                          || {1'b0, seq_number} >= SEQ_LIMIT))
                    begin
                        // good frame that is no ack for this window: ignored
                        state_next = ST_IDLE;
                    end
                    else if (crc_good && ack_count_step == CNT_FULL)
                    begin
                        // last missing ack: window complete
                        awaiting_next  = 1'b0;
                        bitmap_next    = '0;
                        ack_count_next = '0;
                        timeout_next   = '0;
                        fill_next      = '0;
                        single_ev_next = EV_DONE;
                        state_next     = ST_SINGLE;
                    end
                    else
                    begin
                        if (crc_good)
                        begin
                            bitmap_next    = bitmap_reg | seq_onehot;
                            ack_count_next = ack_count_step;
                        end
                        // every other reception, including a new ack, steps the timeout
                        if (timeout_step >= timeout_limit_reg)
                        begin
                            timeout_next      = '0;
                            unacked_only_next = 1'b1;
                            idx_next          = '0;
                            state_next        = ST_SCAN;
                        end
                        else
                        begin
                            timeout_next = timeout_step;
                        end
                    end
                end
            end

            ST_PAD:
            begin
                // fill free slots with empty frames
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wentry = '{ftype: PAD_TYPE, dest: pad_dest_reg, src: pad_src_reg,
                               data: '0};
                if (idx_reg == IDX_LAST)
                begin
                    awaiting_next     = 1'b1;
                    bitmap_next       = '0;
                    ack_count_next    = '0;
                    timeout_next      = '0;
                    unacked_only_next = 1'b0;
                    idx_next          = '0;
                    state_next        = ST_SCAN;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_SCAN:
            begin
                // read slot, or pass over an acknowledged one
                if (!slot_skip)
                begin
                    state_next = ST_EMIT;
                end
                else if (idx_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = EV_TX;
                    out_frame_next = ram_rentry;
                    out_seq_next   = SEQ_W'(idx_reg);
                    out_last_next  = !more_to_send;
                    if (!more_to_send || idx_reg == IDX_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = single_ev_reg;
                    out_frame_next = '0;
                    out_seq_next   = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            fill_reg         <= '0;
            awaiting_reg     <= 1'b0;
            bitmap_reg       <= '0;
            ack_count_reg    <= '0;
            timeout_reg      <= '0;
            unacked_only_reg <= 1'b0;
            single_ev_reg    <= EV_REJECT;
            pad_dest_reg     <= '0;
            pad_src_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            fill_reg         <= fill_next;
            awaiting_reg     <= awaiting_next;
            bitmap_reg       <= bitmap_next;
            ack_count_reg    <= ack_count_next;
            timeout_reg      <= timeout_next;
            unacked_only_reg <= unacked_only_next;
            single_ev_reg    <= single_ev_next;
            pad_dest_reg     <= pad_dest_next;
            pad_src_reg      <= pad_src_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_event_reg <= out_event_next;
        out_frame_reg <= out_frame_next;
        out_seq_reg   <= out_seq_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = out_event_reg;
    assign out_type    = out_frame_reg.ftype;
    assign out_seq     = out_seq_reg;
    assign out_dest    = out_frame_reg.dest;
    assign out_src     = out_frame_reg.src;
    assign out_payload = out_frame_reg.data;
    assign last        = out_last_reg;

    // ack count tracks the distinct acks in the bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        ack_count_reg == CNT_W'($countones(bitmap_reg)))
        else $error("ack count out of step with bitmap");

    // no acks are held while the window is still filling
    assert property (@(posedge clk) disable iff (!rst_n)
        !awaiting_reg |-> bitmap_reg == '0)
        else $error("ack bitmap not clear while filling");

    // a partly filled window never coexists with waiting for acks
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != '0 |-> !awaiting_reg)
        else $error("fill index set while awaiting acks");

    // window walk only happens once the window is out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_EMIT) |-> awaiting_reg)
        else $error("window walk while filling");

endmodule
